// ===== rtl/hmd_pkg.sv =====
package hmd_pkg;

    localparam int unsigned LEN_W = 24;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd30000;

    // header_count codes: 0 (and the unused 5..7) expect a type byte
    localparam logic [2:0] CNT_TYPE    = 3'd0;
    localparam logic [2:0] CNT_LEN_HI  = 3'd1;
    localparam logic [2:0] CNT_LEN_MID = 3'd2;
    localparam logic [2:0] CNT_LEN_LO  = 3'd3;
    localparam logic [2:0] CNT_BODY    = 3'd4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] message_type;
        logic       message_first;
        logic       message_last;
        logic       record_last;
        logic       failed;
    } result_t;

endpackage

// ===== rtl/hmd_parser.sv =====
module hmd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [7:0]                 data_byte,
    input  logic                       record_end,
    input  logic [hmd_pkg::LEN_W-1:0]  max_len,
    output hmd_pkg::result_t           result
);
    import hmd_pkg::*;

    logic [2:0]       header_count_reg, header_count_next;
    logic [7:0]       current_type_reg, current_type_next;
    logic [LEN_W-1:0] remaining_body_reg, remaining_body_next;
    logic             error_latched_reg, error_latched_next;

    logic [LEN_W-1:0] len_shift;
    logic [LEN_W-1:0] body_dec;
    logic             first;
    logic             last;
    logic             fail;

    assign len_shift = {remaining_body_reg[LEN_W-9:0], data_byte};
    assign body_dec  = remaining_body_reg - LEN_W'(1);

    always_comb
    begin
        header_count_next   = header_count_reg;
        current_type_next   = current_type_reg;
        remaining_body_next = remaining_body_reg;
        error_latched_next  = error_latched_reg;
        first = 1'b0;
        last  = 1'b0;
        fail  = 1'b0;

        if (!error_latched_reg)
        begin
            case (header_count_reg)
                CNT_LEN_HI, CNT_LEN_MID:
                begin
                    remaining_body_next = len_shift;
                    header_count_next   = header_count_reg + 3'd1;
                end
                CNT_LEN_LO:
                begin
                    if (len_shift > max_len)
                    begin
                        error_latched_next  = 1'b1;
                        fail                = 1'b1;
                        header_count_next   = CNT_TYPE;
                        remaining_body_next = '0;
                    end
                    else if (len_shift == '0)
                    begin
                        last                = 1'b1;
                        header_count_next   = CNT_TYPE;
                        remaining_body_next = '0;
                    end
                    else
                    begin
                        remaining_body_next = len_shift;
                        header_count_next   = CNT_BODY;
                    end
                end
                CNT_BODY:
                begin
                    remaining_body_next = body_dec;
                    if (body_dec == '0)
                    begin
                        last              = 1'b1;
                        header_count_next = CNT_TYPE;
                    end
                end
                default:
                begin
                    current_type_next   = data_byte;
                    first               = 1'b1;
                    remaining_body_next = '0;
                    header_count_next   = CNT_LEN_HI;
                end
            endcase
        end

        result.record_last = record_end;
        if (error_latched_reg || fail)
        begin
            result.out_byte      = 8'd0;
            result.message_type  = 8'd0;
            result.message_first = 1'b0;
            result.message_last  = 1'b0;
            result.failed        = 1'b1;
        end
        else
        begin
            result.out_byte      = data_byte;
            result.message_type  = current_type_next;
            result.message_first = first;
            result.message_last  = last;
            result.failed        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg   <= CNT_TYPE;
            current_type_reg   <= 8'd0;
            remaining_body_reg <= '0;
            error_latched_reg  <= 1'b0;
        end
        else if (advance)
        begin
            header_count_reg   <= header_count_next;
            current_type_reg   <= current_type_next;
            remaining_body_reg <= remaining_body_next;
            error_latched_reg  <= error_latched_next;
        end
    end

    // failure is sticky until reset
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_latched_reg |=> error_latched_reg)
        else $error("error flag cleared without reset");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= CNT_BODY)
        else $error("header count out of range");

    // a body never runs with nothing left to send
    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg == CNT_BODY |-> remaining_body_reg != '0)
        else $error("body state with zero remaining length");

    a_fail_output: assert property (@(posedge clk) disable iff (!rst_n)
        error_latched_reg |-> result.failed && result.out_byte == 8'd0)
        else $error("transfer after failure not marked failed");

endmodule

// ===== rtl/handshake_message_deframer.sv =====
// Handshake message deframer.
// Input channel (in_valid/in_stall) carries one record payload byte per
// transfer with record_end on the last byte of a record. Output channel
// (out_valid/out_stall) returns exactly one transfer per input byte: the
// byte, its message type, first/last marks and a copy of record_end.
// Messages are a type byte plus 24-bit big-endian length, then the body;
// record boundaries do not affect framing.
// A declared length above max_message_length sets failed on that header
// byte and on every later transfer, with the payload fields zeroed.
// Each byte enters the input register; its parsed result then loads the
// output register, which drives out_valid. Throughput: one byte per cycle
// while out_stall is low, set by the single input register feeding the
// header/length parser and the output register. out_stall holds the output
// register; one more byte can still enter the input register, after which
// in_stall follows out_stall, so no byte is lost. Reset: framing state
// cleared, limit back to 30000, both registers empty. Users must only write
// max_message_length (via max_message_length_we) while idle; not enforced.
module handshake_message_deframer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       max_message_length_we,
    input  logic [hmd_pkg::LEN_W-1:0]  max_message_length,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       record_end,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic [7:0]                 message_type,
    output logic                       message_first,
    output logic                       message_last,
    output logic                       record_last,
    output logic                       failed
);
    import hmd_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic             in_valid_reg;
    logic [7:0]       data_reg;
    logic             rec_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;
    result_t          parsed;
    logic             advance;
    logic             in_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (max_message_length_we)
                max_len_reg <= max_message_length;
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            data_reg <= data_byte;
            rec_reg  <= record_end;
        end
        if (advance)
            out_reg <= parsed;
    end

    hmd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .data_byte  (data_reg),
        .record_end (rec_reg),
        .max_len    (max_len_reg),
        .result     (parsed)
    );

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_reg.out_byte;
    assign message_type  = out_reg.message_type;
    assign message_first = out_reg.message_first;
    assign message_last  = out_reg.message_last;
    assign record_last   = out_reg.record_last;
    assign failed        = out_reg.failed;

    // a held input byte must move once the output slot frees up
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_stall |-> advance)
        else $error("input register held while output free");

    a_out_filled: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("parsed byte not presented");

    a_in_taken: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_valid_reg)
        else $error("input transfer lost");

endmodule
